>>> src/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types and constants for the affinity chunk scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package acs_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_TOTAL_ITER  = 2'd0;
  localparam logic [1:0] CFG_WORKER_CNT  = 2'd1;
  localparam logic [1:0] CFG_CHUNK_FLOOR = 2'd2;

  // Configuration reset values
  localparam logic [15:0] TOTAL_ITER_RST  = 16'd1024;
  localparam logic [3:0]  WORKER_CNT_RST  = 4'd1;
  localparam logic [15:0] CHUNK_FLOOR_RST = 16'd1;

  // Item kinds
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [2:0] worker;
  } acs_in_t;

  typedef struct packed {
    logic        granted;
    logic [15:0] chunk_start;
    logic [15:0] chunk_end;
    logic [15:0] chunk_size;
    logic        stolen;
    logic [2:0]  source_worker;
  } acs_out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic cap;        // capture accepted word
    logic div_part;   // start partition divide
    logic take_q;     // capture quotient and remainder of partition divide
    logic fill;       // write one range entry
    logic rd;         // read range entry at current index
    logic lat;        // take read data, start chunk divide
    logic chunk_ld;   // load clamped chunk size
    logic own_take;   // take own chunk as the grant
    logic scan_init;  // begin steal scan
    logic scan_cmp;   // compare chunk against best, advance index
    logic wr;         // commit grant and update range
    logic res_clr;    // set no-grant result
  } acs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic kind;
    logic worker_bad;
    logic rem_zero;
    logic div_done;
    logic chunk_zero;
    logic best_pos;
    logic idx_last;
  } acs_sts_t;

endpackage
`default_nettype wire

>>> src/affinity_chunk_scheduler_top.sv
// Throughput: one word at a time; the next word is taken once the result is
//   in the output register. Reset clears all ranges to empty and config to
//   defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// affinity_chunk_scheduler_top
// Affinity loop scheduler: partitions iterations and hands out chunks.
// ----------------------------------------------------------------------------
`default_nettype none
module affinity_chunk_scheduler_top #(
  parameter int MAX_WORKERS = 8,
  parameter int ITER_BITS   = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire acs_pkg::acs_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output acs_pkg::acs_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);

  logic [15:0]       total_r;
  logic [3:0]        wcnt_r;
  logic [15:0]       minc_r;
  logic [3:0]        p;
  logic              out_valid_r, out_free, out_load;
  acs_pkg::acs_out_t out_r, res;
  acs_pkg::acs_cmd_t cmd;
  acs_pkg::acs_sts_t sts;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= acs_pkg::TOTAL_ITER_RST;
      wcnt_r  <= acs_pkg::WORKER_CNT_RST;
      minc_r  <= acs_pkg::CHUNK_FLOOR_RST;
    end else if (cfg_valid) begin
      if (cfg_index == acs_pkg::CFG_TOTAL_ITER) begin
        total_r <= cfg_data;
      end
      if (cfg_index == acs_pkg::CFG_WORKER_CNT) begin
        wcnt_r <= cfg_data[3:0];
      end
      if (cfg_index == acs_pkg::CFG_CHUNK_FLOOR) begin
        minc_r <= cfg_data;
      end
    end
  end

  // Active worker count, clamped to 1..MAX_WORKERS
  always_comb begin
    if (wcnt_r == 4'd0) begin
      p = 4'd1;
    end else if ({3'b000, wcnt_r} > 7'(MAX_WORKERS)) begin
      p = 4'(MAX_WORKERS);
    end else begin
      p = wcnt_r;
    end
  end

  acs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .out_load (out_load),
    .sts      (sts),
    .cmd      (cmd)
  );

  acs_dp #(.MAX_WORKERS(MAX_WORKERS), .ITER_BITS(ITER_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cmd         (cmd),
    .p           (p),
    .total_iter  (total_r),
    .chunk_floor (minc_r),
    .sts         (sts),
    .res         (res)
  );

  // Output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> src/acs_ram.sv
// ----------------------------------------------------------------------------
// acs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module acs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/acs_div.sv
// ----------------------------------------------------------------------------
// acs_div
// Restoring divider, one quotient bit per cycle, by a 4-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module acs_div #(
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [3:0]    divisor,
  output logic               done,
  output logic [DW-1:0]      quot,
  output logic [3:0]         remd
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [3:0]    rem_r, rem_nxt;
  logic [3:0]    dsr_r, dsr_nxt;
  logic [4:0]    trial;

  // One shift-subtract step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quo_r[DW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      quo_nxt  = dividend;
      rem_nxt  = 4'd0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = 4'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[3:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign remd = rem_r;

endmodule
`default_nettype wire

>>> src/acs_dp.sv
// ----------------------------------------------------------------------------
// acs_dp
// Scheduler datapath: range store, divider, chunk sizing and grant result.
// ----------------------------------------------------------------------------
`default_nettype none
module acs_dp #(
  parameter int MAX_WORKERS = 8,
  parameter int ITER_BITS   = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire acs_pkg::acs_in_t in_data,
  input  wire acs_pkg::acs_cmd_t cmd,
  input  wire logic [3:0]       p,
  input  wire logic [15:0]      total_iter,
  input  wire logic [15:0]      chunk_floor,
  output acs_pkg::acs_sts_t     sts,
  output acs_pkg::acs_out_t     res
);

  localparam int IB = ITER_BITS;
  localparam int DW = IB + 1;
  localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int XW = (IB + 1 > 16) ? IB + 1 : 16;

  logic [2:0]              worker_r;
  logic [AW-1:0]           idx_r;
  logic [IB-1:0]           rem_r, chunk_r, best_r, bnext_r, blim_r;
  logic [AW-1:0]           src_r;
  logic                    scan_r;
  logic [IB-1:0]           q_r, lo_r;
  logic [3:0]              r_r;
  logic [MAX_WORKERS-1:0]  valid_r;
  logic                    vld_rd_r;
  acs_pkg::acs_out_t       res_r;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [2*IB-1:0]         ram_wdata, ram_rdata;
  logic [IB-1:0]           rd_next, rd_lim, rem_c, hi_c, end_c;
  logic                    in_p, below_r;
  logic                    div_go, div_done;
  logic [DW-1:0]           div_dvd, div_q;
  logic [3:0]              div_r;
  logic [XW-1:0]           sz_a, sz_b;

  acs_ram #(.WIDTH(2 * IB), .DEPTH(MAX_WORKERS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  acs_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_dvd),
    .divisor  (p),
    .done     (div_done),
    .quot     (div_q),
    .remd     (div_r)
  );

  // Read data of an entry never written reads as an empty range
  assign rd_next = vld_rd_r ? ram_rdata[2*IB-1:IB] : '0;
  assign rd_lim  = vld_rd_r ? ram_rdata[IB-1:0] : '0;
  assign rem_c   = (rd_next < rd_lim) ? rd_lim - rd_next : '0;

  // Divider operand select
  assign div_go  = cmd.div_part | (cmd.lat & (rem_c != '0));
  assign div_dvd = cmd.div_part ? DW'(IB'(total_iter))
                                : DW'(rem_c) + DW'(p) - DW'(1);

  // Clamp quotient to the chunk floor and to what remains
  always_comb begin
    sz_a = XW'(div_q);
    if (sz_a < XW'(chunk_floor)) begin
      sz_a = XW'(chunk_floor);
    end
    sz_b = (sz_a > XW'(rem_r)) ? XW'(rem_r) : sz_a;
  end

  // Partition entry for the fill sweep
  assign in_p    = 7'(idx_r) < 7'(p);
  assign below_r = 7'(idx_r) < 7'(r_r);
  assign hi_c    = lo_r + q_r + IB'(below_r);
  assign end_c   = bnext_r + best_r;

  // Range store write port
  always_comb begin
    ram_we    = cmd.fill | cmd.wr;
    ram_waddr = cmd.fill ? idx_r : src_r;
    if (cmd.fill) begin
      ram_wdata = in_p ? {lo_r, hi_c} : '0;
    end else begin
      ram_wdata = {end_c, blim_r};
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[ram_waddr] <= 1'b1;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      worker_r <= in_data.worker;
      idx_r    <= AW'(in_data.worker);
      scan_r   <= 1'b0;
    end
    if (cmd.take_q) begin
      q_r   <= IB'(div_q);
      r_r   <= div_r;
      idx_r <= '0;
      lo_r  <= '0;
    end
    if (cmd.fill) begin
      lo_r  <= hi_c;
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.rd) begin
      vld_rd_r <= valid_r[idx_r];
    end
    if (cmd.lat) begin
      bnext_r <= bnext_r;
      rem_r   <= rem_c;
      if (rem_c == '0) begin
        chunk_r <= '0;
      end
    end
    if (cmd.lat) begin
      lo_r <= rd_next;
      q_r  <= rd_lim;
    end
    if (cmd.chunk_ld) begin
      chunk_r <= IB'(sz_b);
    end
    if (cmd.own_take) begin
      best_r  <= chunk_r;
      src_r   <= idx_r;
      bnext_r <= lo_r;
      blim_r  <= q_r;
    end
    if (cmd.scan_init) begin
      best_r <= '0;
      idx_r  <= '0;
      scan_r <= 1'b1;
    end
    if (cmd.scan_cmp) begin
      if (chunk_r > best_r) begin
        best_r  <= chunk_r;
        src_r   <= idx_r;
        bnext_r <= lo_r;
        blim_r  <= q_r;
      end
      idx_r <= idx_r + AW'(1);
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.res_clr) begin
      res_r <= '0;
    end else if (cmd.wr) begin
      res_r.granted       <= 1'b1;
      res_r.chunk_start   <= 16'(bnext_r);
      res_r.chunk_end     <= 16'(end_c);
      res_r.chunk_size    <= 16'(best_r);
      res_r.stolen        <= scan_r && (7'(src_r) != 7'(worker_r));
      res_r.source_worker <= 3'(src_r);
    end
  end

  assign res = res_r;

  // Status
  assign sts.kind       = in_data.kind;
  assign sts.worker_bad = 7'(in_data.worker) >= 7'(p);
  assign sts.rem_zero   = (rem_c == '0);
  assign sts.div_done   = div_done;
  assign sts.chunk_zero = (chunk_r == '0);
  assign sts.best_pos   = (best_r != '0) || (chunk_r != '0);
  assign sts.idx_last   = (idx_r == AW'(MAX_WORKERS - 1));

endmodule
`default_nettype wire

>>> src/acs_ctrl.sv
// ----------------------------------------------------------------------------
// acs_ctrl
// Scheduler controller: sequences partition, own-range grant and steal scan.
// ----------------------------------------------------------------------------
`default_nettype none
module acs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              out_free,
  output logic                   out_load,
  input  wire acs_pkg::acs_sts_t sts,
  output acs_pkg::acs_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_QDIV = 9'b000000010,
    S_FILL = 9'b000000100,
    S_RD   = 9'b000001000,
    S_LAT  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_CMP  = 9'b001000000,
    S_WR   = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   scan_r, scan_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    cmd       = '0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap  = 1'b1;
          scan_nxt = 1'b0;
          if (sts.kind == acs_pkg::KIND_START) begin
            cmd.div_part = 1'b1;
            state_nxt    = S_QDIV;
          end else if (sts.worker_bad) begin
            cmd.res_clr = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_QDIV: begin
        if (sts.div_done) begin
          cmd.take_q = 1'b1;
          state_nxt  = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.idx_last) begin
          cmd.res_clr = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LAT;
      end
      S_LAT: begin
        cmd.lat   = 1'b1;
        state_nxt = sts.rem_zero ? S_CMP : S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.chunk_ld = 1'b1;
          state_nxt    = S_CMP;
        end
      end
      S_CMP: begin
        if (!scan_r) begin
          if (!sts.chunk_zero) begin
            cmd.own_take = 1'b1;
            state_nxt    = S_WR;
          end else begin
            cmd.scan_init = 1'b1;
            scan_nxt      = 1'b1;
            state_nxt     = S_RD;
          end
        end else begin
          cmd.scan_cmp = 1'b1;
          if (!sts.idx_last) begin
            state_nxt = S_RD;
          end else if (sts.best_pos) begin
            state_nxt = S_WR;
          end else begin
            cmd.res_clr = 1'b1;
            state_nxt   = S_DONE;
          end
        end
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      scan_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/acs_checker.sv
// ----------------------------------------------------------------------------
// acs_checker
// Port-level checks for the affinity chunk scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module acs_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire acs_pkg::acs_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire acs_pkg::acs_out_t out_data
);

  // Hold off new words while one is in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A no-grant word carries all zeros
  a_nogrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.granted |->
      out_data.chunk_size == 16'd0 && out_data.chunk_start == 16'd0 &&
      out_data.chunk_end == 16'd0 && !out_data.stolen &&
      out_data.source_worker == 3'd0)
    else $error("no-grant result not cleared");

  // A grant is never empty
  a_grant_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.granted |-> out_data.chunk_size != 16'd0)
    else $error("empty chunk granted");

  // Drop results on reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind affinity_chunk_scheduler_top acs_checker u_acs_checker (.*);
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the affinity chunk scheduler: a directed table of
// words, directed extremes, then random partition/request traffic over several
// register settings. Results are checked against table grants or a scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;

  localparam int NWK = 8;
  localparam longint CYCLE_LIMIT = 5000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  acs_pkg::acs_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  acs_pkg::acs_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = acs_pkg::CFG_TOTAL_ITER;
  logic [15:0] cfg_data = '0;

  always #5 clk = ~clk;

  affinity_chunk_scheduler_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // scoreboard copy of registers and per-worker ranges
  logic [15:0] sb_total = acs_pkg::TOTAL_ITER_RST;
  logic [3:0]  sb_wcnt = acs_pkg::WORKER_CNT_RST;
  logic [15:0] sb_minc = acs_pkg::CHUNK_FLOOR_RST;
  logic [15:0] sb_next [NWK];
  logic [15:0] sb_limit [NWK];

  acs_pkg::acs_out_t grant_q[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 0;
  bit rx_random = 1;

  function automatic int active_cnt();
    int p;
    p = sb_wcnt;
    if (p == 0) p = 1;
    if (p > NWK) p = NWK;
    return p;
  endfunction

  function automatic int next_chunk(int w, int p);
    int rem, sz;
    if (sb_next[w] >= sb_limit[w]) return 0;
    rem = sb_limit[w] - sb_next[w];
    sz = (rem + p - 1) / p;
    if (sz < sb_minc) sz = sb_minc;
    if (sz > rem) sz = rem;
    return sz;
  endfunction

  // advance the scoreboard by one word, return the grant it yields
  function automatic acs_pkg::acs_out_t schedule_word(acs_pkg::acs_in_t w);
    acs_pkg::acs_out_t r;
    int p, q, rm, lo, hi, src, sz, c;
    bit steal;
    r = '0;
    p = active_cnt();
    if (w.kind == acs_pkg::KIND_START) begin
      q = sb_total / p;
      rm = sb_total % p;
      for (int k = 0; k < NWK; k++) begin
        if (k < p) begin
          lo = k * q + (k < rm ? k : rm);
          hi = (k + 1) * q + ((k + 1) < rm ? k + 1 : rm);
          sb_next[k] = lo[15:0];
          sb_limit[k] = hi[15:0];
        end else begin
          sb_next[k] = '0;
          sb_limit[k] = '0;
        end
      end
      return r;
    end
    if (int'(w.worker) >= p) return r;
    src = w.worker;
    sz = next_chunk(src, p);
    steal = 0;
    if (sz == 0) begin
      steal = 1;
      for (int i = 0; i < NWK; i++) begin
        c = next_chunk(i, p);
        if (c > sz) begin
          sz = c;
          src = i;
        end
      end
      if (sz == 0) return r;
    end
    r.granted = 1'b1;
    r.chunk_start = sb_next[src];
    r.chunk_end = sb_next[src] + sz[15:0];
    r.chunk_size = sz[15:0];
    r.stolen = steal && (src != int'(w.worker));
    r.source_worker = src[2:0];
    sb_next[src] = r.chunk_end;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      acs_pkg::CFG_TOTAL_ITER:  sb_total = val;
      acs_pkg::CFG_WORKER_CNT:  sb_wcnt = val[3:0];
      acs_pkg::CFG_CHUNK_FLOOR: sb_minc = val;
      default: ;
    endcase
  endtask

  // send one word; the expectation is queued at acceptance and valid stays
  // up so that a following word goes out back to back
  task automatic send_word(acs_pkg::acs_in_t w, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    grant_q.push_back(schedule_word(w));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  // receive side: random stall per word, plus a long hold-off on request
  initial begin
    int wait_n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
      wait_n = (rx_random && $urandom_range(0, 2) != 0) ? $urandom_range(0, 18) : 0;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each accepted result word
  always @(posedge clk) begin
    acs_pkg::acs_out_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        $error("unexpected result word %h", out_data);
        errors++;
      end else begin
        e = grant_q.pop_front();
        if (out_data.granted !== e.granted) begin
          $error("granted exp %0d got %0d", e.granted, out_data.granted); errors++;
        end
        if (out_data.chunk_start !== e.chunk_start) begin
          $error("chunk_start exp %0d got %0d", e.chunk_start, out_data.chunk_start);
          errors++;
        end
        if (out_data.chunk_end !== e.chunk_end) begin
          $error("chunk_end exp %0d got %0d", e.chunk_end, out_data.chunk_end); errors++;
        end
        if (out_data.chunk_size !== e.chunk_size) begin
          $error("chunk_size exp %0d got %0d", e.chunk_size, out_data.chunk_size);
          errors++;
        end
        if (out_data.stolen !== e.stolen) begin
          $error("stolen exp %0d got %0d", e.stolen, out_data.stolen); errors++;
        end
        if (out_data.source_worker !== e.source_worker) begin
          $error("source_worker exp %0d got %0d", e.source_worker, out_data.source_worker);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  typedef struct {
    logic              kind;
    logic [2:0]        worker;
    bit                typed;
    acs_pkg::acs_out_t grant;
  } dir_row_t;

  // directed rows; typed grants are the ones plain from the reset settings
  dir_row_t dir_rows[] = '{
    '{acs_pkg::KIND_REQUEST, 3'd0, 1, '0},                     // before any start
    '{acs_pkg::KIND_START,   3'd7, 1, '0},                     // start ignores worker
    '{acs_pkg::KIND_REQUEST, 3'd0, 1, '{1'b1, 16'd0, 16'd1024, 16'd1024, 1'b0, 3'd0}},
    '{acs_pkg::KIND_REQUEST, 3'd0, 1, '0},                     // nothing left
    '{acs_pkg::KIND_REQUEST, 3'd1, 1, '0},                     // worker out of range
    '{acs_pkg::KIND_REQUEST, 3'd7, 1, '0},
    '{acs_pkg::KIND_START,   3'd0, 1, '0},
    '{acs_pkg::KIND_REQUEST, 3'd0, 0, '0}
  };

  acs_pkg::acs_in_t w;
  int n_words;
  initial begin
    for (int k = 0; k < NWK; k++) begin
      sb_next[k] = '0;
      sb_limit[k] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings
    foreach (dir_rows[i]) begin
      w.kind = dir_rows[i].kind;
      w.worker = dir_rows[i].worker;
      send_word(w, $urandom_range(0, 3));
      if (dir_rows[i].typed) grant_q[$] = dir_rows[i].grant;
    end
    drain();

    // extremes: eight workers, stealing, tiny and zero totals, odd counts
    write_reg(acs_pkg::CFG_WORKER_CNT, 16'd8);
    write_reg(acs_pkg::CFG_TOTAL_ITER, 16'd65535);
    write_reg(acs_pkg::CFG_CHUNK_FLOOR, 16'd65535);
    send_word('{acs_pkg::KIND_START, 3'd0}, 0);
    for (int i = 0; i < 9; i++) send_word('{acs_pkg::KIND_REQUEST, i[2:0]}, 0);
    drain();
    write_reg(acs_pkg::CFG_TOTAL_ITER, 16'd0);
    write_reg(acs_pkg::CFG_CHUNK_FLOOR, 16'd0);
    send_word('{acs_pkg::KIND_START, 3'd0}, 0);
    send_word('{acs_pkg::KIND_REQUEST, 3'd3}, 0);
    drain();
    write_reg(acs_pkg::CFG_WORKER_CNT, 16'd0);
    write_reg(acs_pkg::CFG_TOTAL_ITER, 16'd5);
    send_word('{acs_pkg::KIND_START, 3'd0}, 0);
    send_word('{acs_pkg::KIND_REQUEST, 3'd0}, 0);
    send_word('{acs_pkg::KIND_REQUEST, 3'd1}, 0);
    drain();
    write_reg(acs_pkg::CFG_WORKER_CNT, 16'd15);
    send_word('{acs_pkg::KIND_START, 3'd0}, 0);
    for (int i = 0; i < 6; i++) send_word('{acs_pkg::KIND_REQUEST, 3'(7 - i)}, 0);
    drain();

    // random phases, each under fresh settings; the second fills the block
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(acs_pkg::CFG_WORKER_CNT, 16'($urandom_range(0, 15)));
      write_reg(acs_pkg::CFG_TOTAL_ITER, ph == 9 ? 16'd65535 :
                16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400)));
      write_reg(acs_pkg::CFG_CHUNK_FLOOR, ph == 9 ? 16'd1 :
                16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20)));
      rx_random = (ph != 4);
      if (ph == 1) hold_off = 1;
      n_words = 0;
      while (n_words < 165) begin
        w.kind = ($urandom_range(0, 15) == 0) ? acs_pkg::KIND_START : acs_pkg::KIND_REQUEST;
        w.worker = $urandom_range(0, 7);
        send_word(w, (ph == 1 || ph == 4 || $urandom_range(0, 2) == 0) ? 0
                  : $urandom_range(0, 18));
        n_words++;
      end
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
